// ===== hdl/rsm_pkg.sv =====
// Shared types, constants and the exp helper table for the row softmax block.
`timescale 1ns / 1ps
package rsm_pkg;
    localparam logic [15:0] LOG2E_Q14 = 16'd23637;
    localparam logic [15:0] LOGIT_MIN = 16'h8000;

    localparam logic [15:0] REG_ROW_LENGTH = 16'd0;

    typedef enum logic [2:0] {
        ST_FILL,
        ST_SUM,
        ST_DIV,
        ST_EMIT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic store;
        logic clear_row;
        logic rd_start;
        logic acc_en;
        logic div_start;
        logic sum_clear;
    } t_cmd;

    // Status from the datapath.
    typedef struct packed {
        logic exp_valid;
        logic div_done;
    } t_status;

    function automatic logic [16:0] pow2_neg(input logic [4:0] idx);
        logic [16:0] r;
        begin
            case (idx)
                5'd0: r = 17'd65536;
                5'd1: r = 17'd62757;
                5'd2: r = 17'd60097;
                5'd3: r = 17'd57549;
                5'd4: r = 17'd55109;
                5'd5: r = 17'd52773;
                5'd6: r = 17'd50535;
                5'd7: r = 17'd48393;
                5'd8: r = 17'd46341;
                5'd9: r = 17'd44376;
                5'd10: r = 17'd42495;
                5'd11: r = 17'd40693;
                5'd12: r = 17'd38968;
                5'd13: r = 17'd37316;
                5'd14: r = 17'd35734;
                5'd15: r = 17'd34219;
                5'd16: r = 17'd32768;
                default: r = 17'd0;
            endcase
            return r;
        end
    endfunction
endpackage

// ===== hdl/rsm_exp.sv =====
// Pipelined fixed point exp of a max-subtracted logit.
`timescale 1ns / 1ps
module rsm_exp import rsm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [16:0] i_mag,
    output logic        o_valid,
    output logic [16:0] o_exp
);
    logic        r_v1, r_v2, r_v3;
    logic [32:0] r_t;
    logic [16:0] r_hi;
    logic [16:0] r_hi2;
    logic [16:0] r_diff;
    logic [11:0] r_frac;
    logic [6:0]  r_k1, r_k2;
    logic [28:0] r_prod;
    logic [16:0] r_exp;
    logic [16:0] w_v;
    logic [17:0] w_round;
    logic [4:0]  w_idx;

    assign w_idx = {1'b0, r_t[25:22]};
    assign w_v = r_hi2 - 17'((r_prod + 29'd2048) >> 12);
    assign w_round = (r_k2 == 7'd0) ? {1'b0, w_v} :
                     ({1'b0, w_v} + (18'd1 << (r_k2 - 7'd1)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
        r_t    <= i_mag * {1'b0, LOG2E_Q14};
        r_k1   <= r_t[32:26];
        r_hi   <= pow2_neg(w_idx);
        r_diff <= pow2_neg(w_idx) - pow2_neg(w_idx + 5'd1);
        r_frac <= r_t[21:10];
        r_prod <= r_diff * r_frac;
        r_hi2  <= r_hi;
        r_k2   <= r_k1;
        if (r_k2 > 7'd17) begin
            r_exp <= 17'd0;
        end else begin
            r_exp <= 17'(w_round >> r_k2);
        end
    end

    // Stage 1 multiply, stage 2 table, stage 3 interpolation, stage 4 shift.
    logic r_v4;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else begin
            r_v4 <= r_v3;
        end
    end
    assign o_valid = r_v4;
    assign o_exp   = r_exp;
endmodule

// ===== hdl/rsm_div.sv =====
// Restoring divider: rounded quotient (e * 65536 + sum / 2) / sum, one bit a cycle.
`timescale 1ns / 1ps
module rsm_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [16:0] i_exp,
    input  logic [22:0] i_sum,
    output logic        o_done,
    output logic [15:0] o_quot
);
    logic [33:0] r_num;
    logic [23:0] r_rem;
    logic [33:0] r_q;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [22:0] r_den;
    logic [23:0] w_trial;

    assign w_trial = {r_rem[22:0], r_num[33]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd34;
                r_num  <= {i_exp, 16'd0} + {12'd0, i_sum[22:1]};
                r_den  <= i_sum;
                r_rem  <= 24'd0;
                r_q    <= 34'd0;
            end else if (r_busy) begin
                r_num <= {r_num[32:0], 1'b0};
                if (w_trial >= {1'b0, r_den}) begin
                    r_rem <= w_trial - {1'b0, r_den};
                    r_q   <= {r_q[32:0], 1'b1};
                end else begin
                    r_rem <= w_trial;
                    r_q   <= {r_q[32:0], 1'b0};
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = (r_q[33:16] != 18'd0) ? 16'hFFFF : r_q[15:0];
endmodule

// ===== hdl/rsm_datapath.sv =====
// Row buffer, maximum tracking, exp unit, summation and normalisation.
`timescale 1ns / 1ps
module rsm_datapath import rsm_pkg::*; #(
    parameter int ROW_MAX = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cmd                       i_cmd,
    input  logic [15:0]                i_logit,
    input  logic [$clog2(ROW_MAX)-1:0] i_wr_addr,
    input  logic [$clog2(ROW_MAX)-1:0] i_rd_addr,
    output t_status                    o_status,
    output logic [16:0]                o_exp,
    output logic [15:0]                o_quot
);
    logic [15:0] r_mem [ROW_MAX];
    logic [15:0] r_rd_data;
    logic        r_rd_v;
    logic [15:0] r_max;
    logic [22:0] r_sum;
    logic [16:0] r_exp_hold;
    logic [16:0] w_mag;
    logic [16:0] w_diff;
    logic        w_exp_v;
    logic [16:0] w_exp;

    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_mem[i_wr_addr] <= i_logit;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max  <= LOGIT_MIN;
            r_sum  <= 23'd0;
            r_rd_v <= 1'b0;
        end else begin
            r_rd_v <= i_cmd.rd_start;
            if (i_cmd.clear_row) begin
                r_max <= LOGIT_MIN;
            end else if (i_cmd.store && ($signed(i_logit) > $signed(r_max))) begin
                r_max <= i_logit;
            end
            if (i_cmd.sum_clear) begin
                r_sum <= 23'd0;
            end else if (i_cmd.acc_en && w_exp_v) begin
                r_sum <= r_sum + {6'd0, w_exp};
            end
        end
        if (w_exp_v) begin
            r_exp_hold <= w_exp;
        end
    end

    assign w_diff = {r_max[15], r_max} - {r_rd_data[15], r_rd_data};
    assign w_mag  = w_diff;

    rsm_exp u_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_rd_v),
        .i_mag   (w_mag),
        .o_valid (w_exp_v),
        .o_exp   (w_exp)
    );

    // The division starts in the cycle the exp value appears, so it takes it directly.
    rsm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_exp   (w_exp),
        .i_sum   (r_sum),
        .o_done  (o_status.div_done),
        .o_quot  (o_quot)
    );

    assign o_status.exp_valid = w_exp_v;
    assign o_exp = r_exp_hold;
endmodule

// ===== hdl/rsm_ctrl.sv =====
// Controller state machine: fill, sum pass, then one division per element.
`timescale 1ns / 1ps
module rsm_ctrl import rsm_pkg::*; #(
    parameter int ROW_MAX = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [6:0]                 i_len,
    input  t_status                    i_status,
    input  logic [15:0]                i_quot,
    output t_cmd                       o_cmd,
    output logic [$clog2(ROW_MAX)-1:0] o_wr_addr,
    output logic [$clog2(ROW_MAX)-1:0] o_rd_addr,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [15:0]                o_probability,
    output logic [5:0]                 o_position,
    output logic                       o_last_of_row
);
    localparam int AW = $clog2(ROW_MAX);

    t_state      r_state, n_state;
    logic [6:0]  r_fill, n_fill;
    logic [6:0]  r_cnt, n_cnt;
    logic [6:0]  r_got, n_got;
    logic        r_wait, n_wait;
    logic        r_ov, n_ov;
    logic [15:0] r_prob, n_prob;
    logic [5:0]  r_pos, n_pos;
    logic        r_last, n_last;
    logic [6:0]  w_len;
    logic [6:0]  w_wr;
    logic        w_acc;

    always_comb begin
        if (i_len == 7'd0) begin
            w_len = 7'd1;
        end else if (i_len > 7'(ROW_MAX)) begin
            w_len = 7'(ROW_MAX);
        end else begin
            w_len = i_len;
        end
    end

    assign w_wr = (r_fill >= 7'(ROW_MAX)) ? 7'(ROW_MAX - 1) : r_fill;
    assign w_acc = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != ST_FILL);
    assign o_wr_addr = w_wr[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_FILL;
            r_fill  <= 7'd0;
            r_cnt   <= 7'd0;
            r_got   <= 7'd0;
            r_wait  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_cnt   <= n_cnt;
            r_got   <= n_got;
            r_wait  <= n_wait;
            r_ov    <= n_ov;
        end
        r_prob <= n_prob;
        r_pos  <= n_pos;
        r_last <= n_last;
    end

    always_comb begin
        n_state = r_state;
        n_fill  = r_fill;
        n_cnt   = r_cnt;
        n_got   = r_got;
        n_wait  = r_wait;
        n_ov    = r_ov;
        n_prob  = r_prob;
        n_pos   = r_pos;
        n_last  = r_last;
        o_cmd   = '0;
        o_rd_addr = r_cnt[AW-1:0];
        if (r_ov && !i_out_stall) begin
            n_ov = 1'b0;
        end
        case (r_state)
            ST_FILL: begin
                if (w_acc) begin
                    o_cmd.store = 1'b1;
                    n_fill = w_wr + 7'd1;
                    if (w_wr + 7'd1 >= w_len) begin
                        n_state = ST_SUM;
                        n_cnt = 7'd0;
                        n_got = 7'd0;
                        o_cmd.sum_clear = 1'b1;
                    end
                end
            end
            ST_SUM: begin
                o_cmd.acc_en = 1'b1;
                if (r_cnt < r_fill) begin
                    o_cmd.rd_start = 1'b1;
                    n_cnt = r_cnt + 7'd1;
                end
                if (i_status.exp_valid) begin
                    n_got = r_got + 7'd1;
                    if (r_got + 7'd1 == r_fill) begin
                        n_state = ST_DIV;
                        n_cnt = 7'd0;
                        n_got = 7'd0;
                        n_wait = 1'b0;
                    end
                end
            end
            ST_DIV: begin
                // Read one element, rerun exp, then divide it by the row sum.
                if (!r_wait) begin
                    o_cmd.rd_start = 1'b1;
                    n_wait = 1'b1;
                end else if (i_status.exp_valid) begin
                    o_cmd.div_start = 1'b1;
                end else if (i_status.div_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!r_ov || !i_out_stall) begin
                    n_ov   = 1'b1;
                    n_prob = i_quot;
                    n_pos  = r_cnt[5:0];
                    n_last = (r_cnt + 7'd1 == r_fill);
                    n_wait = 1'b0;
                    if (r_cnt + 7'd1 == r_fill) begin
                        n_state = ST_FILL;
                        n_fill = 7'd0;
                        o_cmd.clear_row = 1'b1;
                        n_cnt = 7'd0;
                    end else begin
                        n_state = ST_DIV;
                        n_cnt = r_cnt + 7'd1;
                    end
                end
            end
            default: n_state = ST_FILL;
        endcase
    end

    assign o_out_valid   = r_ov;
    assign o_probability = r_prob;
    assign o_position    = r_pos;
    assign o_last_of_row = r_last;
endmodule

// ===== hdl/row_softmax_top.sv =====
// Row softmax top level: register port, controller and datapath.
// Usage: logits arrive on i_logit with i_valid; a request is taken when i_valid
// is high and o_stall is low. Results leave on o_probability, o_position and
// o_last_of_row with o_valid, taken when i_stall is low.
// Row length is to be written over the APB port at address 0 only while the
// block is idle; the block itself does not enforce this. Filling stores each
// accepted logit. Once a row is complete the block stops taking logits, streams
// the row through the four stage exp pipeline to build the sum, then for each
// element reruns exp and divides by the sum in a 34 step bit-serial divider.
// The next row starts after the last result is registered. A stalled receiver
// holds the output register and the sequencer waits.
// Reset empties the row, sets the maximum to the most negative logit and the
// row length to 64; the row buffer contents are left as they are.
`timescale 1ns / 1ps
module row_softmax_top import rsm_pkg::*; #(
    parameter int ROW_MAX = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_logit,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_probability,
    output logic [5:0]  o_position,
    output logic        o_last_of_row,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [6:0]  r_len;
    t_cmd        w_cmd;
    t_status     w_status;
    logic [16:0] w_exp;
    logic [15:0] w_quot;
    logic [$clog2(ROW_MAX)-1:0] w_wr, w_rd;

    assign pready = 1'b1;
    assign prdata = ({14'd0, paddr} == REG_ROW_LENGTH) ? {25'd0, r_len} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= 7'd64;
        end else if (psel && penable && pwrite
                     && ({14'd0, paddr} == REG_ROW_LENGTH)) begin
            r_len <= pwdata[6:0];
        end
    end

    rsm_ctrl #(.ROW_MAX(ROW_MAX)) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .o_in_stall    (o_stall),
        .i_len         (r_len),
        .i_status      (w_status),
        .i_quot        (w_quot),
        .o_cmd         (w_cmd),
        .o_wr_addr     (w_wr),
        .o_rd_addr     (w_rd),
        .o_out_valid   (o_valid),
        .i_out_stall   (i_stall),
        .o_probability (o_probability),
        .o_position    (o_position),
        .o_last_of_row (o_last_of_row)
    );

    rsm_datapath #(.ROW_MAX(ROW_MAX)) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .i_logit   (i_logit),
        .i_wr_addr (w_wr),
        .i_rd_addr (w_rd),
        .o_status  (w_status),
        .o_exp     (w_exp),
        .o_quot    (w_quot)
    );

    logic w_unused;
    assign w_unused = ^w_exp;
endmodule

// ===== verif/row_softmax_checker.sv =====
// Checker for the row softmax block: watches both channels, predicts rows, compares results.
`timescale 1ns / 1ps
module row_softmax_checker #(
    parameter int ROW_MAX = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_stall_in,
    input  logic [15:0] i_logit,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [15:0] i_probability,
    input  logic [5:0]  i_position,
    input  logic        i_last_of_row,
    input  logic        i_cfg_wr,
    input  logic [1:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending,
    output int          o_rows,
    output int          o_results
);
    import rsm_pkg::*;

    typedef struct {
        logic [15:0] probability;
        logic [5:0]  position;
        logic        last_of_row;
    } t_prob;

    t_prob             prob_queue[$];
    logic signed [15:0] row_buf[ROW_MAX];
    int                 fill;
    logic signed [15:0] row_peak;
    logic [6:0]         row_len;

    int unsigned pow2_tab[17] = '{65536, 62757, 60097, 57549, 55109, 52773, 50535,
                                  48393, 46341, 44376, 42495, 40693, 38968, 37316,
                                  35734, 34219, 32768};

    function automatic int unsigned exp_of_gap(int x, int peak);
        longint unsigned mag, t, k;
        int unsigned     f, idx, frac, hi, lo, v;
        mag = (x < peak) ? longint'(peak - x) : 0;
        t = mag * 23637;
        k = t >> 26;
        f = int'((t >> 10) & 64'hFFFF);
        idx = f >> 12;
        frac = f & 12'hFFF;
        hi = pow2_tab[idx];
        lo = pow2_tab[idx + 1];
        v = hi - (((hi - lo) * frac + 2048) >> 12);
        if (k == 0) return v;
        if (k > 17) return 0;
        return (v + (1 << (k - 1))) >> k;
    endfunction

    task automatic finish_row();
        int unsigned     total;
        longint unsigned e, p;
        t_prob           r;
        total = 0;
        for (int i = 0; i < fill; i++)
            total = (total + exp_of_gap(row_buf[i], row_peak)) & 23'h7FFFFF;
        for (int i = 0; i < fill; i++) begin
            e = exp_of_gap(row_buf[i], row_peak);
            p = (total != 0) ? ((e << 16) + (total >> 1)) / total : 0;
            if (p > 65535) p = 65535;
            r.probability = p[15:0];
            r.position = i[5:0];
            r.last_of_row = (i + 1 == fill);
            prob_queue.push_back(r);
        end
        fill = 0;
        row_peak = -16'sd32768;
        o_rows++;
    endtask

    always @(posedge i_clk) begin
        int    len;
        t_prob want;
        if (!i_rst_n) begin
            fill = 0;
            row_peak = -16'sd32768;
            row_len = 7'd64;
        end else begin
            if (i_cfg_wr && i_cfg_addr == REG_ROW_LENGTH[1:0])
                row_len = i_cfg_data[6:0];
            if (i_valid && !i_stall_in) begin
                len = (row_len == 0) ? 1 : (row_len > ROW_MAX) ? ROW_MAX : row_len;
                if (fill >= ROW_MAX) fill = ROW_MAX - 1;
                row_buf[fill] = i_logit;
                if ($signed(i_logit) > row_peak) row_peak = i_logit;
                fill++;
                if (fill >= len) finish_row();
            end
            if (i_out_valid && !i_out_stall) begin
                o_results++;
                if (prob_queue.size() == 0) begin
                    $error("unexpected result: position %0d probability %0d",
                           i_position, i_probability);
                    o_errors++;
                end else begin
                    want = prob_queue.pop_front();
                    if (i_probability !== want.probability) begin
                        $error("probability: expected %0d, got %0d",
                               want.probability, i_probability);
                        o_errors++;
                    end
                    if (i_position !== want.position) begin
                        $error("position: expected %0d, got %0d", want.position, i_position);
                        o_errors++;
                    end
                    if (i_last_of_row !== want.last_of_row) begin
                        $error("last_of_row: expected %0d, got %0d",
                               want.last_of_row, i_last_of_row);
                        o_errors++;
                    end
                end
            end
        end
        o_pending = prob_queue.size();
    end

    initial begin
        o_errors = 0;
        o_pending = 0;
        o_rows = 0;
        o_results = 0;
    end
endmodule

// ===== verif/row_softmax_top_test.sv =====
// Testbench top for the row softmax block: stimulus, register writes and verdict.
`timescale 1ns / 1ps
module row_softmax_top_test;
    import rsm_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [15:0] i_logit = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [15:0] o_probability;
    logic [5:0]  o_position;
    logic        o_last_of_row;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int errors, pending, rows, results;
    int send_idle = 0, recv_idle = 0;
    int idle_cycles = 0;
    int sent = 0;

    row_softmax_top u_top (.*);

    row_softmax_checker u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .i_stall_in(o_stall), .i_logit(i_logit),
        .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_probability(o_probability), .i_position(o_position),
        .i_last_of_row(o_last_of_row),
        .i_cfg_wr(psel && penable && pwrite && pready), .i_cfg_addr(paddr),
        .i_cfg_data(pwdata),
        .o_errors(errors), .o_pending(pending), .o_rows(rows), .o_results(results)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // The receiver stalls at random, changing only on the falling edge.
    always @(negedge i_clk)
        i_stall <= ($urandom_range(99) < recv_idle);

    // Watchdog on cycles in which neither channel moves a request or result.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n)
            idle_cycles = 0;
        else if (++idle_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic write_row_length(input logic [31:0] value);
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= REG_ROW_LENGTH[1:0]; pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic drain();
        while (pending != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
    endtask

    // Sends one logit; the valid is held over back-to-back requests.
    task automatic send_logit(input logic [15:0] value);
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_logit <= value;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
        sent++;
    endtask

    function automatic logic [15:0] rand_logit();
        case ($urandom_range(3))
            0: return 16'($urandom);
            1: return 16'($signed(16'($urandom_range(8192))) - 16'sd4096);
            2: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    initial begin
        logic [15:0] directed[$];
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: extremes, single rows, zero length and oversized length.
        send_idle = 8; recv_idle = 61;
        write_row_length(4);
        directed = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF,
                     16'h8000, 16'h8000, 16'h8000, 16'h8000,
                     16'h1000, 16'h0FFF, 16'h5555, 16'hAAAA};
        foreach (directed[i]) send_logit(directed[i]);
        i_valid <= 1'b0;
        drain();
        write_row_length(0);
        send_logit(16'h7FFF);
        send_logit(16'h8000);
        i_valid <= 1'b0;
        drain();
        write_row_length(32'h7F);
        for (int i = 0; i < 64; i++) send_logit(i[0] ? 16'h8000 : 16'(i << 9));
        i_valid <= 1'b0;
        drain();

        // Mid-row change of length: shrink below the count already buffered.
        write_row_length(8);
        repeat (5) send_logit(rand_logit());
        i_valid <= 1'b0;
        repeat (100) @(negedge i_clk);
        write_row_length(3);
        send_logit(rand_logit());
        i_valid <= 1'b0;
        drain();

        // Random rows in three idling phases; a new length is written before each row.
        for (int phase = 0; phase < 3; phase++) begin
            send_idle = (phase == 0) ? 8 : (phase == 1) ? 61 : 0;
            recv_idle = (phase == 0) ? 61 : (phase == 1) ? 8 : 0;
            for (int r = 0; r < 4; r++) begin
                int len;
                len = (r == 0) ? 1 : (r == 1) ? 32 : $urandom_range(2, 12);
                write_row_length(len);
                for (int i = 0; i < len && sent < 240 + phase * 80; i++)
                    send_logit(rand_logit());
                i_valid <= 1'b0;
                drain();
            end
        end

        $display("Covered %0d logits in %0d rows, %0d results checked,", sent, rows, results);
        $display("row lengths 0, 1 to 12, 32 and 127, with a mid-row length change.");
        if (errors == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
